[hdl/vertex_color_modifier_chain_assert.svh]
// Assertion macros shared by the vertex colour modifier chain modules.
`ifndef VERTEX_COLOR_MODIFIER_CHAIN_ASSERT_SVH
`define VERTEX_COLOR_MODIFIER_CHAIN_ASSERT_SVH

// A property that must hold in the same cycle as its antecedent.
`define VCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A property whose consequence must hold in the following cycle.
`define VCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/vcm_pkg.sv]
// Shared types and constants of the vertex colour modifier chain.
package vcm_pkg;

  // Modifier kind codes.
  localparam logic [3:0] KIND_COLOR_SET   = 4'd0;
  localparam logic [3:0] KIND_ALPHA_SET   = 4'd1;
  localparam logic [3:0] KIND_COLOR_SCALE = 4'd2;
  localparam logic [3:0] KIND_ALPHA_SCALE = 4'd3;
  localparam logic [3:0] KIND_DOT_FIRST   = 4'd4;
  localparam logic [3:0] KIND_DOT_LAST    = 4'd11;

  // Datapath widths of the fixed point factor and the divider.
  localparam int FACTOR_W   = 56;
  localparam int DIVIDEND_W = 55;
  localparam int DIVISOR_W  = 18;
  localparam int STEP_W     = 6;

  localparam logic signed [FACTOR_W-1:0] Q26_ONE  = 56'sd67108864;
  localparam logic signed [64:0]         Q26_HALF = 65'sd33554432;

  // One request as it travels through the queue.
  typedef struct packed {
    logic        is_color;
    logic [2:0]  slot;
    logic [3:0]  kind;
    logic [15:0] mod_x;
    logic [15:0] mod_y;
    logic [15:0] mod_z;
    logic [15:0] range_low;
    logic [15:0] range_high;
    logic [15:0] normal_x;
    logic [15:0] normal_y;
    logic [15:0] normal_z;
    logic [31:0] color_word;
  } item_t;

  // Back end sequencer states.
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_FETCH = 9'b000000010,
    ST_SEL   = 9'b000000100,
    ST_DOT   = 9'b000001000,
    ST_SQR   = 9'b000010000,
    ST_PREP  = 9'b000100000,
    ST_DIV   = 9'b001000000,
    ST_FIN   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } back_state_t;

endpackage

[hdl/vcm_front.sv]
// Front end: accepts requests, drops loads to absent slots, queues the rest.
module vcm_front import vcm_pkg::*; #(
  parameter int MOD_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  item_t       item_i,
  output logic        pop_valid_o,
  output item_t       pop_item_o,
  input  logic        pop_i
);

  localparam int DEPTH = 2;

  item_t       queue_r [DEPTH];
  logic [1:0]  count_r, count_nxt;
  logic        wr_ptr_r, rd_ptr_r;
  logic        accept, keep, push;
  logic [5:0]  slot_wide;

  // Classify: a colour is always kept, a load only if its slot exists.
  assign slot_wide = 6'(item_i.slot);
  assign keep      = item_i.is_color || (slot_wide < 6'(MOD_SLOTS));
  assign busy      = (count_r == 2'(DEPTH));
  assign accept    = start && !busy;
  assign push      = accept && keep;

  assign pop_valid_o = (count_r != 2'd0);
  assign pop_item_o  = queue_r[rd_ptr_r];

  // Occupancy count.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop_i) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && pop_i) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop_i) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= item_i;
    end
  end

`include "vertex_color_modifier_chain_assert.svh"

  `VCM_ASSERT_NOW(a_pop_nonempty, pop_i, count_r != 2'd0, "pop from an empty queue")
  `VCM_ASSERT_NEXT(a_push_grows, push && !pop_i, count_r == $past(count_r) + 2'd1, "push lost")
  `VCM_ASSERT_NEXT(a_pop_shrinks, pop_i && !push, count_r == $past(count_r) - 2'd1, "pop lost")

endmodule

[hdl/vcm_back.sv]
// Back end: modifier table and the sequencer that applies modifiers to a colour.
module vcm_back import vcm_pkg::*; #(
  parameter int MOD_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [3:0]  mod_count_i,
  input  logic        pop_valid_i,
  input  item_t       pop_item_i,
  output logic        pop_o,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha
);

  localparam int IDX_W = (MOD_SLOTS > 1) ? $clog2(MOD_SLOTS) : 1;
  localparam int CNT_W = $clog2(MOD_SLOTS + 1);

  // Modifier table.
  logic [3:0]  kind_mem [MOD_SLOTS];
  logic [47:0] vec_mem  [MOD_SLOTS];
  logic [31:0] rng_mem  [MOD_SLOTS];

  back_state_t state_r, state_nxt;
  logic [3:0]  kind_r;
  logic signed [15:0] vx_r, vy_r, vz_r, lo_r, hi_r;
  logic signed [15:0] nx_r, ny_r, nz_r, nx_nxt, ny_nxt, nz_nxt;
  logic [7:0]  ch_r [4];
  logic [7:0]  ch_nxt [4];
  logic signed [FACTOR_W-1:0] c_r, c_nxt;
  logic [1:0]  k_r, k_nxt, j_r, j_nxt;
  logic [CNT_W-1:0] s_r, s_nxt, count_r, count_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic        neg_r, neg_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic        load_now, is_dot;
  logic [3:0]  kind_off;
  logic [5:0]  slot_wide;
  logic [IDX_W-1:0] wr_idx;

  // Decoding of the dot kinds.
  assign kind_off = kind_r - KIND_DOT_FIRST;
  always_comb begin
    is_dot = (kind_r inside {[KIND_DOT_FIRST:KIND_DOT_LAST]});
  end

  assign pop_o     = (state_r == ST_IDLE) && pop_valid_i;
  assign load_now  = pop_o && !pop_item_i.is_color;
  assign slot_wide = 6'(pop_item_i.slot);
  assign wr_idx    = slot_wide[IDX_W-1:0];

  // Table writes and the registered read of one entry.
  always_ff @(posedge clk) begin
    if (load_now) begin
      kind_mem[wr_idx] <= pop_item_i.kind;
      vec_mem[wr_idx]  <= {pop_item_i.mod_z, pop_item_i.mod_y, pop_item_i.mod_x};
      rng_mem[wr_idx]  <= {pop_item_i.range_high, pop_item_i.range_low};
    end
    if (state_r == ST_FETCH) begin
      kind_r <= kind_mem[s_r[IDX_W-1:0]];
      vx_r   <= $signed(vec_mem[s_r[IDX_W-1:0]][15:0]);
      vy_r   <= $signed(vec_mem[s_r[IDX_W-1:0]][31:16]);
      vz_r   <= $signed(vec_mem[s_r[IDX_W-1:0]][47:32]);
      lo_r   <= $signed(rng_mem[s_r[IDX_W-1:0]][15:0]);
      hi_r   <= $signed(rng_mem[s_r[IDX_W-1:0]][31:16]);
    end
  end

  // Dot product: one component product per cycle.
  logic signed [15:0] n_sel, v_sel;
  logic signed [31:0] dot_prod;
  always_comb begin
    case (k_r)
      2'd0:    begin n_sel = nx_r; v_sel = vx_r; end
      2'd1:    begin n_sel = ny_r; v_sel = vy_r; end
      default: begin n_sel = nz_r; v_sel = vz_r; end
    endcase
  end
  assign dot_prod = n_sel * v_sel;

  // Square of the dot product, rounded back to Q.26.
  logic signed [FACTOR_W-1:0] c_mag;
  logic [31:0] sq_in;
  logic [63:0] sq_sum;
  assign c_mag  = c_r[FACTOR_W-1] ? -c_r : c_r;
  assign sq_in  = c_mag[31:0];
  assign sq_sum = (sq_in * sq_in) + 64'd33554432;

  // Remap operands for the rounded division.
  logic signed [FACTOR_W-1:0] num;
  logic signed [16:0] den;
  logic [FACTOR_W-1:0] num_mag;
  logic [16:0] den_mag;
  assign num     = (c_r - (FACTOR_W'(lo_r) <<< 14)) <<< 12;
  assign den     = {hi_r[15], hi_r} - {lo_r[15], lo_r};
  assign num_mag = num[FACTOR_W-1] ? 56'(-num) : 56'(num);
  assign den_mag = den[16] ? 17'(-den) : 17'(den);

  // One restoring division step.
  logic [DIVISOR_W:0] div_sh;
  logic               div_ge;
  assign div_sh = {rem_r, quo_r[DIVIDEND_W-1]};
  assign div_ge = (div_sh >= {1'b0, dvs_r});

  // Channel update: multiplier and addend for the current channel.
  logic [7:0]  ch_cur;
  logic signed [15:0] v_ch;
  logic signed [24:0] v255;
  logic signed [FACTOR_W-1:0] m_ch;
  logic signed [39:0] a_ch;
  logic signed [64:0] t_ch, t_rnd;
  logic [7:0]  ch_res;
  logic        alpha_ch;
  assign ch_cur   = ch_r[j_r];
  assign alpha_ch = (j_r == 2'd3);
  always_comb begin
    case (j_r)
      2'd1:    v_ch = vy_r;
      2'd2:    v_ch = vz_r;
      default: v_ch = vx_r;
    endcase
  end
  assign v255 = v_ch * 25'sd255;
  always_comb begin
    m_ch = Q26_ONE;
    a_ch = 40'sd0;
    case (kind_r)
      KIND_COLOR_SET: begin
        if (!alpha_ch) begin
          m_ch = '0;
          a_ch = 40'(v255) <<< 14;
        end
      end
      KIND_ALPHA_SET: begin
        if (alpha_ch) begin
          m_ch = '0;
          a_ch = 40'(v255) <<< 14;
        end
      end
      KIND_COLOR_SCALE: begin
        if (!alpha_ch) begin
          m_ch = FACTOR_W'(v_ch) <<< 14;
        end
      end
      KIND_ALPHA_SCALE: begin
        if (alpha_ch) begin
          m_ch = FACTOR_W'(v_ch) <<< 14;
        end
      end
      default: begin
        if (is_dot && (kind_off[1] == alpha_ch)) begin
          m_ch = c_r;
        end
      end
    endcase
  end
  assign t_ch  = m_ch * $signed({1'b0, ch_cur}) + 65'(a_ch);
  assign t_rnd = t_ch + Q26_HALF;
  always_comb begin
    if (t_ch[64]) begin
      ch_res = 8'd0;
    end else if (|t_rnd[64:34]) begin
      ch_res = 8'd255;
    end else begin
      ch_res = t_rnd[33:26];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    s_nxt     = s_r;
    count_nxt = count_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    quo_nxt   = quo_r;
    neg_nxt   = neg_r;
    step_nxt  = step_r;
    nx_nxt    = nx_r;
    ny_nxt    = ny_r;
    nz_nxt    = nz_r;
    for (int i = 0; i < 4; i++) begin
      ch_nxt[i] = ch_r[i];
    end
    case (state_r)
      ST_IDLE: begin
        if (pop_valid_i && pop_item_i.is_color) begin
          for (int i = 0; i < 4; i++) begin
            ch_nxt[i] = pop_item_i.color_word[8*i +: 8];
          end
          nx_nxt = $signed(pop_item_i.normal_x);
          ny_nxt = $signed(pop_item_i.normal_y);
          nz_nxt = $signed(pop_item_i.normal_z);
          s_nxt  = '0;
          if (6'(mod_count_i) > 6'(MOD_SLOTS)) begin
            count_nxt = CNT_W'(MOD_SLOTS);
          end else begin
            count_nxt = CNT_W'(mod_count_i);
          end
          state_nxt = (mod_count_i == 4'd0) ? ST_DONE : ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_SEL;
      end
      ST_SEL: begin
        c_nxt     = '0;
        k_nxt     = 2'd0;
        j_nxt     = 2'd0;
        state_nxt = is_dot ? ST_DOT : ST_DONE;
        if (!is_dot) begin
          state_nxt = ST_FIN;
        end
      end
      ST_DOT: begin
        c_nxt = c_r + FACTOR_W'(dot_prod);
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd2) begin
          // The counter returns to zero so that the final step sees no quotient.
          k_nxt = 2'd0;
          if (kind_off[2]) begin
            state_nxt = ST_SQR;
          end else if (kind_off[0]) begin
            state_nxt = ST_PREP;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SQR: begin
        c_nxt     = FACTOR_W'({18'd0, sq_sum[63:26]});
        state_nxt = kind_off[0] ? ST_PREP : ST_FIN;
      end
      ST_PREP: begin
        if (den == 17'sd0) begin
          c_nxt     = '0;
          state_nxt = ST_FIN;
        end else begin
          quo_nxt   = {num_mag[DIVIDEND_W-2:0], 1'b0} + DIVIDEND_W'(den_mag);
          dvs_nxt   = {den_mag, 1'b0};
          rem_nxt   = '0;
          neg_nxt   = num[FACTOR_W-1] ^ den[16];
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = div_ge ? DIVISOR_W'(div_sh - {1'b0, dvs_r}) : div_sh[DIVISOR_W-1:0];
        quo_nxt  = {quo_r[DIVIDEND_W-2:0], div_ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIVIDEND_W - 1)) begin
          k_nxt     = 2'd3;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // After a division the quotient gets its sign, then channels update.
        if (k_r == 2'd3) begin
          c_nxt = neg_r ? -FACTOR_W'({1'b0, quo_r}) : FACTOR_W'({1'b0, quo_r});
          k_nxt = 2'd0;
        end else begin
          ch_nxt[j_r] = ch_res;
          j_nxt       = j_r + 2'd1;
          if (j_r == 2'd3) begin
            s_nxt     = s_r + CNT_W'(1);
            state_nxt = ((s_r + CNT_W'(1)) == count_r) ? ST_DONE : ST_FETCH;
          end
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= 2'd0;
      j_r     <= 2'd0;
      s_r     <= '0;
      count_r <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      s_r     <= s_nxt;
      count_r <= count_nxt;
      step_r  <= step_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    c_r   <= c_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
    nx_r  <= nx_nxt;
    ny_r  <= ny_nxt;
    nz_r  <= nz_nxt;
    for (int i = 0; i < 4; i++) begin
      ch_r[i] <= ch_nxt[i];
    end
  end

  // Result strobe and channels.
  assign out_valid = (state_r == ST_DONE);
  assign out_red   = ch_r[0];
  assign out_green = ch_r[1];
  assign out_blue  = ch_r[2];
  assign out_alpha = ch_r[3];

`include "vertex_color_modifier_chain_assert.svh"

  `VCM_ASSERT_NOW(a_pop_idle, pop_o, state_r == ST_IDLE, "request taken while busy")
  `VCM_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe held two cycles")
  `VCM_ASSERT_NOW(a_div_nonzero, state_r == ST_DIV, dvs_r != '0, "division by zero width range")

endmodule

[hdl/vertex_color_modifier_chain.sv]
// Vertex colour modifier chain: a load is written to the back end table after
// it leaves the two-entry queue. A colour passes, per applied slot, through
// fetch, select and channel update, with dot product steps for a dot kind, a
// square step for a square and the bit-serial divider for a remap.
// Requests enter one per cycle until two wait; the result strobe cannot stall.
// Reset (rst_n low, synchronous) empties the queue and clears mod_count.
module vertex_color_modifier_chain import vcm_pkg::*; #(
  parameter int MOD_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [2:0]  in_slot,
  input  logic [3:0]  in_mod_kind,
  input  logic signed [15:0] in_mod_x,
  input  logic signed [15:0] in_mod_y,
  input  logic signed [15:0] in_mod_z,
  input  logic signed [15:0] in_range_low,
  input  logic signed [15:0] in_range_high,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic [31:0] in_color_word,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  item_t      item;
  item_t      pop_item;
  logic       pop_valid, pop;
  logic [3:0] mod_count_r;

  // Pack the request fields.
  assign item = '{
    is_color:   in_command,
    slot:       in_slot,
    kind:       in_mod_kind,
    mod_x:      in_mod_x,
    mod_y:      in_mod_y,
    mod_z:      in_mod_z,
    range_low:  in_range_low,
    range_high: in_range_high,
    normal_x:   in_normal_x,
    normal_y:   in_normal_y,
    normal_z:   in_normal_z,
    color_word: in_color_word
  };

  // Modifier count register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_count_r <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      mod_count_r <= cfg_data;
    end
  end

  vcm_front #(.MOD_SLOTS(MOD_SLOTS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .item_i      (item),
    .pop_valid_o (pop_valid),
    .pop_item_o  (pop_item),
    .pop_i       (pop)
  );

  vcm_back #(.MOD_SLOTS(MOD_SLOTS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .mod_count_i (mod_count_r),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_o       (pop),
    .out_valid   (out_valid),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_alpha   (out_alpha)
  );

endmodule

[dv/vertex_color_modifier_chain_test.sv]
// Self-checking testbench for the vertex color modifier chain.
module vertex_color_modifier_chain_test;
  import vcm_pkg::*;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_COLOR = 1'b1;
  localparam int SLOTS = 8;
  // Bits of the dot variant index (kind minus the first dot kind).
  localparam int REMAP_BIT  = 0;
  localparam int ALPHA_BIT  = 1;
  localparam int SQUARE_BIT = 2;
  localparam longint ONE_Q26  = 64'sd67108864;
  localparam longint HALF_Q26 = 64'sd33554432;
  localparam int DRAIN_CYCLES = 600;
  localparam int STALL_LIMIT  = 5000;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_command;
  logic [2:0] in_slot;
  logic [3:0] in_mod_kind;
  logic signed [15:0] in_mod_x, in_mod_y, in_mod_z;
  logic signed [15:0] in_range_low, in_range_high;
  logic signed [15:0] in_normal_x, in_normal_y, in_normal_z;
  logic [31:0] in_color_word;
  logic out_valid;
  logic [7:0] out_red, out_green, out_blue, out_alpha;
  logic cfg_valid;
  logic cfg_ready;
  logic [3:0] cfg_data;

  // Predictor copy of the modifier table and the applied count.
  logic [3:0]  slot_kind [SLOTS];
  logic [47:0] slot_vector [SLOTS];
  logic [31:0] slot_range [SLOTS];
  logic [3:0]  applied_count;

  logic [31:0] expected_colors [$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  vertex_color_modifier_chain i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_slot(in_slot), .in_mod_kind(in_mod_kind),
    .in_mod_x(in_mod_x), .in_mod_y(in_mod_y), .in_mod_z(in_mod_z),
    .in_range_low(in_range_low), .in_range_high(in_range_high),
    .in_normal_x(in_normal_x), .in_normal_y(in_normal_y),
    .in_normal_z(in_normal_z), .in_color_word(in_color_word),
    .out_valid(out_valid), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .out_alpha(out_alpha),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint sext(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  // Rounded division, ties away from zero.
  function automatic longint divide_nearest(longint n, longint d);
    longint unsigned un, ud, q;
    un = magnitude(n);
    ud = magnitude(d);
    q = (un * 2 + ud) / (ud * 2);
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [7:0] scale_channel(longint m, longint a, logic [7:0] ch);
    longint t;
    longint unsigned r;
    t = m * longint'(ch) + a;
    if (t < 0) return 8'd0;
    r = longint'(t + HALF_Q26) >>> 26;
    return r > 255 ? 8'd255 : r[7:0];
  endfunction

  // Walks the active modifiers over one colour and returns the packed RGBA.
  function automatic logic [31:0] modify_color(logic [15:0] nx16, logic [15:0] ny16,
                                               logic [15:0] nz16, logic [31:0] word);
    logic [7:0] ch [4];
    longint m [4];
    longint a [4];
    longint nx, ny, nz, vx, vy, vz, lo, hi, c, den;
    longint unsigned u;
    logic [3:0] kind, variant;
    int count;
    nx = sext(nx16);
    ny = sext(ny16);
    nz = sext(nz16);
    for (int j = 0; j < 4; j++) ch[j] = word[8*j +: 8];
    count = applied_count < SLOTS ? applied_count : SLOTS;
    for (int s = 0; s < count; s++) begin
      vx = sext(slot_vector[s][15:0]);
      vy = sext(slot_vector[s][31:16]);
      vz = sext(slot_vector[s][47:32]);
      lo = sext(slot_range[s][15:0]);
      hi = sext(slot_range[s][31:16]);
      kind = slot_kind[s];
      for (int j = 0; j < 4; j++) begin
        m[j] = ONE_Q26;
        a[j] = 0;
      end
      if (kind == KIND_COLOR_SET) begin
        m[0] = 0; m[1] = 0; m[2] = 0;
        a[0] = vx * 255 * 16384;
        a[1] = vy * 255 * 16384;
        a[2] = vz * 255 * 16384;
      end else if (kind == KIND_ALPHA_SET) begin
        m[3] = 0;
        a[3] = vx * 255 * 16384;
      end else if (kind == KIND_COLOR_SCALE) begin
        m[0] = vx * 16384;
        m[1] = vy * 16384;
        m[2] = vz * 16384;
      end else if (kind == KIND_ALPHA_SCALE) begin
        m[3] = vx * 16384;
      end else if (kind <= KIND_DOT_LAST) begin
        variant = kind - KIND_DOT_FIRST;
        c = nx * vx + ny * vy + nz * vz;
        if (variant[SQUARE_BIT]) begin
          u = magnitude(c);
          c = longint'((u * u + longint'(HALF_Q26)) >> 26);
        end
        if (variant[REMAP_BIT]) begin
          den = hi - lo;
          c = (den == 0) ? 0 : divide_nearest((c - lo * 16384) * 4096, den);
        end
        if (variant[ALPHA_BIT]) m[3] = c;
        else begin
          m[0] = c; m[1] = c; m[2] = c;
        end
      end
      for (int j = 0; j < 4; j++) ch[j] = scale_channel(m[j], a[j], ch[j]);
    end
    return {ch[3], ch[2], ch[1], ch[0]};
  endfunction

  // Sends one request and updates the predictor when it is taken.
  task automatic send_request(item_t req);
    logic taken;
    in_command <= req.is_color;
    in_slot <= req.slot;
    in_mod_kind <= req.kind;
    in_mod_x <= req.mod_x;
    in_mod_y <= req.mod_y;
    in_mod_z <= req.mod_z;
    in_range_low <= req.range_low;
    in_range_high <= req.range_high;
    in_normal_x <= req.normal_x;
    in_normal_y <= req.normal_y;
    in_normal_z <= req.normal_z;
    in_color_word <= req.color_word;
    start <= 1'b1;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    if (req.is_color == CMD_COLOR) begin
      expected_colors.push_back(modify_color(req.normal_x, req.normal_y,
                                             req.normal_z, req.color_word));
    end else begin
      slot_kind[req.slot] = req.kind;
      slot_vector[req.slot] = {req.mod_z, req.mod_y, req.mod_x};
      slot_range[req.slot] = {req.range_high, req.range_low};
    end
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Writes the modifier count once the block has drained.
  task automatic write_count(logic [3:0] value);
    logic taken;
    start <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    applied_count = value;
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(0, 8192)) - 4096);
      3: return 16'(int'($urandom_range(0, 32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic item_t load_item(logic [2:0] slot, logic [3:0] kind);
    item_t r;
    r = '0;
    r.is_color = CMD_LOAD;
    r.slot = slot;
    r.kind = kind;
    r.mod_x = pick_value();
    r.mod_y = pick_value();
    r.mod_z = pick_value();
    r.range_low = pick_value();
    r.range_high = ($urandom_range(0, 9) == 0) ? r.range_low : pick_value();
    r.normal_x = 16'($urandom);
    r.normal_y = 16'($urandom);
    r.normal_z = 16'($urandom);
    r.color_word = $urandom;
    return r;
  endfunction

  function automatic item_t color_item();
    item_t r;
    r = load_item(3'($urandom), 4'($urandom));
    r.is_color = CMD_COLOR;
    r.normal_x = pick_value();
    r.normal_y = pick_value();
    r.normal_z = pick_value();
    return r;
  endfunction

  // Colors with no modifier applied pass through unchanged.
  task automatic test_count_zero();
    item_t r;
    r = color_item();
    r.color_word = 32'hFFFF_FFFF;
    send_request(r);
    r = color_item();
    r.color_word = 32'h0000_0000;
    send_request(r);
  endtask

  // Fills every slot with a distinct kind, including a zero-width range.
  task automatic test_table_fill();
    logic [3:0] kinds [SLOTS];
    item_t r;
    kinds = '{KIND_COLOR_SET, KIND_ALPHA_SET, KIND_COLOR_SCALE, KIND_ALPHA_SCALE,
              4'd5, 4'd7, 4'd9, KIND_DOT_LAST};
    for (int s = 0; s < SLOTS; s++) begin
      r = load_item(3'(s), kinds[s]);
      if (s == 4) r.range_high = r.range_low;
      send_request(r);
    end
  endtask

  // Runs colors over the full table and past it, with extreme inputs.
  task automatic test_full_chain();
    item_t r;
    write_count(4'd8);
    r = color_item();
    r.normal_x = 16'h7FFF; r.normal_y = 16'h7FFF; r.normal_z = 16'h7FFF;
    r.color_word = 32'hFFFF_FFFF;
    send_request(r);
    r = color_item();
    r.normal_x = 16'h8000; r.normal_y = 16'h8000; r.normal_z = 16'h8000;
    r.color_word = 32'h0000_0000;
    send_request(r);
    write_count(4'd15);
    send_request(color_item());
    send_request(color_item());
  endtask

  // Phases of random loads and colors under a fixed list of counts and random sender gaps.
  task automatic test_random_traffic();
    logic [3:0] counts [10];
    item_t r;
    counts = '{4'd1, 4'd0, 4'd8, 4'd15, 4'd2, 4'd4, 4'd9, 4'd3, 4'd1, 4'd6};
    for (int p = 0; p < 10; p++) begin
      write_count(counts[p]);
      for (int i = 0; i < 70; i++) begin
        if ($urandom_range(0, 9) < 3) r = load_item(3'($urandom), 4'($urandom));
        else r = color_item();
        send_request(r);
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          if (p % 3 != 0) pause_sender($urandom_range(1, 8));
        end else begin
          burst_left--;
        end
      end
    end
  endtask

  // Checks each result strobe against the oldest expected colour.
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_valid) begin
      if (expected_colors.size() == 0) begin
        $display("%0t: unexpected result %h", $time,
                 {out_alpha, out_blue, out_green, out_red});
        errors++;
      end else begin
        want = expected_colors.pop_front();
        if (out_red !== want[7:0]) begin
          $display("%0t: red expected %h actual %h", $time, want[7:0], out_red);
          errors++;
        end
        if (out_green !== want[15:8]) begin
          $display("%0t: green expected %h actual %h", $time, want[15:8], out_green);
          errors++;
        end
        if (out_blue !== want[23:16]) begin
          $display("%0t: blue expected %h actual %h", $time, want[23:16], out_blue);
          errors++;
        end
        if (out_alpha !== want[31:24]) begin
          $display("%0t: alpha expected %h actual %h", $time, want[31:24], out_alpha);
          errors++;
        end
      end
    end
  end

  // Ends the run when no request moves for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("vertex_color_modifier_chain regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_command <= CMD_LOAD;
    in_slot <= '0;
    in_mod_kind <= '0;
    in_mod_x <= '0; in_mod_y <= '0; in_mod_z <= '0;
    in_range_low <= '0; in_range_high <= '0;
    in_normal_x <= '0; in_normal_y <= '0; in_normal_z <= '0;
    in_color_word <= '0;
    applied_count = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_count_zero();
    test_table_fill();
    test_full_chain();
    test_random_traffic();
    start <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_colors.size() == 0) begin
      $display("vertex_color_modifier_chain regression: pass");
    end else begin
      $display("vertex_color_modifier_chain regression: fail");
    end
    $finish;
  end

endmodule
